// File: src/aes_cmac_128_tag_defines.svh
// Assertion macros used by the asserting module aes_cmac_128_tag.
`ifndef AES_CMAC_128_TAG_DEFINES_SVH
`define AES_CMAC_128_TAG_DEFINES_SVH

// Check that an antecedent implies a consequent in the next cycle.
`define CMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define CMAC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/cmac_pkg.sv
`timescale 1ns / 1ps
package cmac_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned CountW = 5;
  localparam int unsigned RoundW = 4;
  localparam logic [RoundW-1:0] LastRound = 4'd10;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [7:0] RbConst = 8'h87;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  typedef enum logic [0:0] {
    RegKeyHigh = 1'b0,
    RegKeyLow  = 1'b1
  } reg_idx_e;

  // Classified block handed from front to back.
  typedef struct packed {
    logic [BlockW-1:0] blk;   // block, padded and masked if short and last
    logic              last;
    logic              full;  // last block uses K1, else K2
  } job_t;

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [BlockW-1:0] gf_double(logic [BlockW-1:0] v);
    return {v[BlockW-2:0], 1'b0} ^ {{(BlockW-8){1'b0}}, (v[BlockW-1] ? RbConst : 8'h00)};
  endfunction

  // Byte j of a block, byte 0 most significant.
  function automatic logic [7:0] get_byte(logic [BlockW-1:0] v, int unsigned j);
    return v[BlockW-1-8*j -: 8];
  endfunction

  // SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
  function automatic logic [BlockW-1:0] aes_round(logic [BlockW-1:0] s,
                                                  logic [BlockW-1:0] rk, logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [BlockW-1:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[c*4+j] = SBOX[get_byte(s, ((c + j) % 4) * 4 + j)];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int j = 0; j < 16; j++) begin
      r[BlockW-1-8*j -: 8] = t[j];
    end
    return r ^ rk;
  endfunction

  // Next round key from the current one and its round constant.
  function automatic logic [BlockW-1:0] next_rkey(logic [BlockW-1:0] k, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// File: src/cmac_if.sv
`timescale 1ns / 1ps
interface cmac_in_if;
  logic                          valid;
  logic                          ready;
  logic [cmac_pkg::HalfW-1:0]    data_high;
  logic [cmac_pkg::HalfW-1:0]    data_low;
  logic [cmac_pkg::CountW-1:0]   byte_count;
  logic                          last;
  modport source (output valid, data_high, data_low, byte_count, last, input ready);
  modport sink   (input valid, data_high, data_low, byte_count, last, output ready);
endinterface

interface cmac_out_if;
  logic                       valid;
  logic                       ready;
  logic [cmac_pkg::HalfW-1:0] tag_high;
  logic [cmac_pkg::HalfW-1:0] tag_low;
  modport source (output valid, tag_high, tag_low, input ready);
  modport sink   (input valid, tag_high, tag_low, output ready);
endinterface

interface cmac_cfg_if;
  logic                       valid;
  logic                       ready;
  logic                       index;
  logic [cmac_pkg::HalfW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/aes_cmac_128_tag.sv
// A last input beat passes the queue, the AES rounds and the tag register before its tag beat.
// Blocks pass one at a time through the round-per-cycle AES loop (CBC chaining); after
// reset or a key write, subkey derivation runs before the next block is taken.
// Reset (rst_ni low, asynchronous) clears key, chain, subkeys and all handshake state.
`timescale 1ns / 1ps
`include "aes_cmac_128_tag_defines.svh"
module aes_cmac_128_tag (
  input  logic     clk_i,
  input  logic     rst_ni,
  cmac_cfg_if.sink cfg_i,
  cmac_in_if.sink  in_i,
  cmac_out_if.source out_o
);

  logic [cmac_pkg::HalfW-1:0] key_hi_q, key_lo_q;
  logic stale_q;
  cmac_pkg::job_t job;
  logic job_valid, job_ready, busy;
  logic cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  // Hold key registers; mark subkeys stale on a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      stale_q  <= 1'b0;
    end else begin
      stale_q <= cfg_fire;
      if (cfg_fire) begin
        unique case (cmac_pkg::reg_idx_e'(cfg_i.index))
          cmac_pkg::RegKeyHigh: key_hi_q <= cfg_i.data;
          cmac_pkg::RegKeyLow:  key_lo_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  cmac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  cmac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .key_i       ({key_hi_q, key_lo_q}),
    .key_stale_i (stale_q || cfg_fire),
    .busy_o      (busy),
    .out_o       (out_o)
  );

  `CMAC_ASSERT_SAME(a_no_job_on_stale, clk_i, rst_ni, stale_q, !job_ready,
                    "job taken while subkeys stale")
  `CMAC_ASSERT_NEXT(a_tag_holds, clk_i, rst_ni, out_o.valid && !out_o.ready,
                    out_o.valid && $stable(out_o.tag_high), "tag dropped while stalled")
  `CMAC_ASSERT_SAME(a_busy_on_tag, clk_i, rst_ni, out_o.valid, busy,
                    "tag pending but back end idle")

endmodule

// File: src/cmac_front.sv
`timescale 1ns / 1ps
module cmac_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  cmac_in_if.sink            in_i,
  output cmac_pkg::job_t     job_o,
  output logic               job_valid_o,
  input  logic               job_ready_i
);

  // Two-entry queue of classified blocks.
  cmac_pkg::job_t mem_q [2];
  logic wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cmac_pkg::job_t job_d;
  logic [cmac_pkg::BlockW-1:0] raw, mask, pad;
  logic push, pop;

  assign raw = {in_i.data_high, in_i.data_low};

  // Pad a short last block: keep leading bytes, then 0x80, then zeros.
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      mask[cmac_pkg::BlockW-1-8*j -: 8] = (in_i.byte_count > 5'(j)) ? 8'hff : 8'h00;
      pad[cmac_pkg::BlockW-1-8*j -: 8]  = (in_i.byte_count == 5'(j)) ?
                                          cmac_pkg::PadByte : 8'h00;
    end
    job_d.last = in_i.last;
    job_d.full = (in_i.byte_count >= 5'd16);
    if (in_i.last && !job_d.full) begin
      job_d.blk = (raw & mask) | pad;
    end else begin
      job_d.blk = raw;
    end
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = mem_q[rptr_q];

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store the beat.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= job_d;
  end

endmodule

// File: src/cmac_back.sv
`timescale 1ns / 1ps
module cmac_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmac_pkg::job_t              job_i,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  input  logic [cmac_pkg::BlockW-1:0] key_i,
  input  logic                        key_stale_i,
  output logic                        busy_o,
  cmac_out_if.source                  out_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StOut  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [cmac_pkg::BlockW-1:0] st_q, rk_q, chain_q, k1_q, k2_q;
  logic [cmac_pkg::RoundW-1:0] rnd_q;
  logic [7:0] rc_q;
  logic ready_q, deriving_q, last_q;
  logic [cmac_pkg::BlockW-1:0] tag_q;
  logic tvalid_q;
  logic [cmac_pkg::BlockW-1:0] rk_next, st_next, blk_in, sk;
  logic start, finish, l_base;

  assign rk_next = cmac_pkg::next_rkey(rk_q, rc_q);
  assign st_next = cmac_pkg::aes_round(st_q, rk_next, rnd_q != cmac_pkg::LastRound);
  assign finish  = (state_q == StRun) && (rnd_q == cmac_pkg::LastRound);

  // Accept a job only when idle, subkeys exist and the tag slot can take a result.
  assign job_ready_o = (state_q == StIdle) && ready_q && !key_stale_i
                       && !(tvalid_q && !out_o.ready);
  assign start  = job_valid_i && job_ready_o;
  assign l_base = (state_q == StIdle) && (!ready_q || key_stale_i) && job_valid_i;
  assign sk     = job_i.full ? k1_q : k2_q;
  assign blk_in = job_i.last ? (job_i.blk ^ sk ^ chain_q) : (job_i.blk ^ chain_q);
  assign busy_o = (state_q != StIdle) || tvalid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (start || l_base) state_d = StRun;
      StRun:  if (finish) state_d = StIdle;
      StOut:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Sequence the rounds, one per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      rnd_q      <= '0;
      ready_q    <= 1'b0;
      deriving_q <= 1'b0;
      last_q     <= 1'b0;
      tvalid_q   <= 1'b0;
      chain_q    <= '0;
      k1_q       <= '0;
      k2_q       <= '0;
    end else begin
      state_q <= state_d;
      if (key_stale_i) ready_q <= 1'b0;
      if (out_o.valid && out_o.ready) tvalid_q <= 1'b0;
      if (start || l_base) begin
        rnd_q      <= 4'd1;
        deriving_q <= l_base;
        last_q     <= job_i.last && !l_base;
      end else if (state_q == StRun) begin
        rnd_q <= rnd_q + 4'd1;
      end
      if (finish) begin
        if (deriving_q) begin
          k1_q    <= cmac_pkg::gf_double(st_next);
          k2_q    <= cmac_pkg::gf_double(cmac_pkg::gf_double(st_next));
          ready_q <= 1'b1;
        end else if (last_q) begin
          chain_q  <= '0;
          tvalid_q <= 1'b1;
        end else begin
          chain_q <= st_next;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start || l_base) begin
      st_q <= (l_base ? '0 : blk_in) ^ key_i;
      rk_q <= key_i;
      rc_q <= 8'h01;
    end else if (state_q == StRun) begin
      st_q <= st_next;
      rk_q <= rk_next;
      rc_q <= cmac_pkg::xtime(rc_q);
    end
    if (finish && last_q && !deriving_q) tag_q <= st_next;
  end

  assign out_o.valid    = tvalid_q;
  assign out_o.tag_high = tag_q[cmac_pkg::BlockW-1:cmac_pkg::HalfW];
  assign out_o.tag_low  = tag_q[cmac_pkg::HalfW-1:0];

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned NumRandom = 500;
  localparam int unsigned SettleCycles = 40;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic [63:0] tag_high;
    logic [63:0] tag_low;
  } tag_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cmac_cfg_if cfg();
  cmac_in_if  blk_if();
  cmac_out_if tag_if();

  aes_cmac_128_tag DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg.sink),
    .in_i  (blk_if.sink),
    .out_o (tag_if.source)
  );

  int unsigned err_count = 0;

  // Print one line per mismatch and count it.
  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // AES-128 encryption of one block, written out round by round.
  function automatic logic [7:0] dbl8(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t aes_encrypt(block_t key, block_t pt);
    logic [7:0] st [16];
    logic [7:0] sh [16];
    logic [7:0] rk [16];
    logic [7:0] rcon, tmp, a0, a1, a2, a3, al;
    block_t res;
    rcon = 8'h01;
    for (int j = 0; j < 16; j++) begin
      rk[j] = key[127-8*j -: 8];
      st[j] = pt[127-8*j -: 8] ^ rk[j];
    end
    for (int r = 1; r <= 10; r++) begin
      // expand next round key
      tmp = rk[12];
      rk[0] = rk[0] ^ cmac_pkg::SBOX[rk[13]] ^ rcon;
      rk[1] = rk[1] ^ cmac_pkg::SBOX[rk[14]];
      rk[2] = rk[2] ^ cmac_pkg::SBOX[rk[15]];
      rk[3] = rk[3] ^ cmac_pkg::SBOX[tmp];
      for (int j = 4; j < 16; j++) rk[j] = rk[j] ^ rk[j-4];
      rcon = dbl8(rcon);
      // substitute and shift rows
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) sh[c*4+j] = cmac_pkg::SBOX[st[((c+j)%4)*4+j]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = sh[c*4]; a1 = sh[c*4+1]; a2 = sh[c*4+2]; a3 = sh[c*4+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          sh[c*4]   = a0 ^ al ^ dbl8(a0 ^ a1);
          sh[c*4+1] = a1 ^ al ^ dbl8(a1 ^ a2);
          sh[c*4+2] = a2 ^ al ^ dbl8(a2 ^ a3);
          sh[c*4+3] = a3 ^ al ^ dbl8(a3 ^ a0);
        end
      end
      for (int j = 0; j < 16; j++) st[j] = sh[j] ^ rk[j];
    end
    for (int j = 0; j < 16; j++) res[127-8*j -: 8] = st[j];
    return res;
  endfunction

  // Tag predictor and queue of tags still to come.
  class tag_scoreboard;
    block_t key;
    block_t chain;
    block_t k1, k2;
    bit     keys_fresh;
    tag_t   pending_tags[$];

    function new();
      key = '0;
      chain = '0;
      k1 = '0;
      k2 = '0;
      keys_fresh = 1'b0;
    endfunction

    function void write_key(cmac_pkg::reg_idx_e idx, logic [63:0] val);
      if (idx == cmac_pkg::RegKeyHigh) key[127:64] = val;
      else key[63:0] = val;
      keys_fresh = 1'b0;
    endfunction

    function block_t times_x(block_t v);
      return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
    endfunction

    // Note an accepted block and predict the tag if it ends a message.
    function void note_block(logic [63:0] dh, logic [63:0] dl, logic [4:0] cnt,
                             logic lst);
      block_t m;
      tag_t t;
      if (!keys_fresh) begin
        k1 = times_x(aes_encrypt(key, '0));
        k2 = times_x(k1);
        keys_fresh = 1'b1;
      end
      m = {dh, dl};
      if (!lst) begin
        chain = aes_encrypt(key, chain ^ m);
        return;
      end
      if (cnt >= 16) begin
        m = m ^ k1;
      end else begin
        for (int j = 0; j < 16; j++)
          if (j >= cnt) m[127-8*j -: 8] = (j == cnt) ? cmac_pkg::PadByte : 8'h00;
        m = m ^ k2;
      end
      t = aes_encrypt(key, chain ^ m);
      chain = '0;
      pending_tags.push_back(t);
    endfunction

    // Compare a received tag with the oldest prediction.
    task check_tag(logic [63:0] th, logic [63:0] tl);
      tag_t exp_t;
      if (pending_tags.size() == 0) begin
        report($sformatf("unexpected tag %h_%h", th, tl));
        return;
      end
      exp_t = pending_tags.pop_front();
      if (th !== exp_t.tag_high)
        report($sformatf("tag_high %h, want %h", th, exp_t.tag_high));
      if (tl !== exp_t.tag_low)
        report($sformatf("tag_low %h, want %h", tl, exp_t.tag_low));
    endtask
  endclass

  tag_scoreboard sb = new();

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cfg.valid = 1'b0;
    cfg.index = cmac_pkg::RegKeyHigh;
    cfg.data = '0;
    blk_if.valid = 1'b0;
    blk_if.data_high = '0;
    blk_if.data_low = '0;
    blk_if.byte_count = '0;
    blk_if.last = 1'b0;
    tag_if.ready = 1'b0;
  end

  // Pick a gap: none when gaps are off, else mostly none or short, now and then long.
  function automatic int unsigned pick_gap(bit busy_phase);
    int unsigned p;
    p = $urandom_range(99);
    if (!busy_phase) return 0;
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  bit gaps_on = 1'b1;

  // Sink side: stall the tag channel at random.
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      g = pick_gap(gaps_on);
      if (g != 0) begin
        tag_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      tag_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(tag_if.valid && tag_if.ready)) @(posedge clk_i);
      sb.check_tag(tag_if.tag_high, tag_if.tag_low);
    end
  end

  task automatic write_key(cmac_pkg::reg_idx_e idx, logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    sb.write_key(idx, val);
  endtask

  task automatic send_block(logic [63:0] dh, logic [63:0] dl, logic [4:0] cnt,
                            logic lst);
    int unsigned g;
    g = pick_gap(gaps_on);
    if (g != 0) begin
      blk_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    blk_if.valid <= 1'b1;
    blk_if.data_high <= dh;
    blk_if.data_low <= dl;
    blk_if.byte_count <= cnt;
    blk_if.last <= lst;
    @(posedge clk_i);
    while (!blk_if.ready) @(posedge clk_i);
    sb.note_block(dh, dl, cnt, lst);
  endtask

  // Drop valid and hold until all tags are out and the engine has settled.
  task automatic drain();
    blk_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_tags.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [4:0] rand_count();
    int unsigned p;
    p = $urandom_range(9);
    if (p < 3) return 5'd16;
    if (p == 3) return 5'd0;
    if (p == 4) return 5'($urandom_range(31, 17));
    return 5'($urandom_range(15, 1));
  endfunction

  // Key phase: write both halves, then random messages.
  task automatic run_key(logic [63:0] kh, logic [63:0] kl, int unsigned n_blocks);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    drain();
    write_key(cmac_pkg::RegKeyHigh, kh);
    write_key(cmac_pkg::RegKeyLow, kl);
    while (sent < n_blocks) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(3, 1);
      for (int i = 1; i < len; i++) send_block(rand64(), rand64(), 5'($urandom()), 1'b0);
      send_block(rand64(), rand64(), rand_count(), 1'b1);
      sent += len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Standard test key, then messages exercising the corners.
    write_key(cmac_pkg::RegKeyHigh, 64'h2b7e151628aed2a6);
    write_key(cmac_pkg::RegKeyLow, 64'habf7158809cf4f3c);
    send_block('0, '0, 5'd0, 1'b1);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd7, 1'b0);
    send_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd31, 1'b1);
    send_block('1, '1, 5'd15, 1'b1);
    send_block('1, '1, 5'd1, 1'b0);
    send_block('1, '1, 5'd0, 1'b1);
    send_block('1, '0, 5'd8, 1'b1);
    send_block('0, '1, 5'd17, 1'b1);
    send_block(rand64(), rand64(), 5'd16, 1'b0);
    send_block(rand64(), rand64(), 5'd16, 1'b0);
    send_block(rand64(), rand64(), 5'd9, 1'b1);

    // Key write in the middle of a message keeps the chain.
    send_block(rand64(), rand64(), 5'd3, 1'b0);
    drain();
    write_key(cmac_pkg::RegKeyLow, 64'h0);
    send_block(rand64(), rand64(), 5'd12, 1'b1);

    // Key extremes, then random keys; one phase without gaps.
    run_key('0, '0, 40);
    run_key('1, '1, 40);
    gaps_on = 1'b0;
    run_key(rand64(), rand64(), 60);
    gaps_on = 1'b1;
    for (int k = 0; k < 6; k++) run_key(rand64(), rand64(), 60);

    drain();
    if (err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("testbench failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/cmac_pkg.sv
src/cmac_if.sv
src/cmac_front.sv
src/cmac_back.sv
src/aes_cmac_128_tag.sv
sim/testbench.sv
